FILE: rtl/interrupt_line_router_coalescer_assert.svh
// ----------------------------------------------------------------------------
// interrupt line router assertion macros
// shared assertion forms for the router and coalescer checks
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_LINE_ROUTER_COALESCER_ASSERT_SVH
`define INTERRUPT_LINE_ROUTER_COALESCER_ASSERT_SVH

// condition and consequence in the same cycle
`define ILRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define ILRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ilrc_pkg.sv
// ----------------------------------------------------------------------------
// ilrc_pkg
// types and fixed constants of the interrupt line router and coalescer
// ----------------------------------------------------------------------------
package ilrc_pkg;

    typedef enum logic [2:0] {
        OP_REGISTER    = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_RAISE       = 3'd2,
        OP_ACK         = 3'd3,
        OP_START_TIMER = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LINE  = 3'd1,
        ST_BUSY      = 3'd2,
        ST_STRAY     = 3'd3,
        ST_NOTIFY    = 3'd4,
        ST_COALESCED = 3'd5
    } status_t;

    localparam int OPCODE_W     = 3;
    localparam int STATUS_W     = 3;
    localparam int LINE_W       = 5;
    localparam int OWNER_W      = 8;
    localparam int MASK_BITS    = 16;
    localparam int MISS_W       = 16;
    localparam int TOTAL_W      = 32;
    localparam int USERS_W      = 4;
    localparam int HITS_W       = 6;
    localparam int WIDE_OWNER_W = 16;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 104;

    localparam int SLAVE_BASE   = 8;
    localparam int CASCADE_LINE = 2;
    localparam int TIMER_LINE   = 0;

    localparam logic [MASK_BITS-1:0] MASK_ALL    = 16'hFFFF;
    localparam logic [MISS_W-1:0]    MISS_MAX    = 16'hFFFF;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = 32'hFFFF_FFFF;
    localparam logic [USERS_W-1:0]   CASCADE_MAX = 4'hF;

endpackage

FILE: rtl/ilrc_release_scan.sv
// ----------------------------------------------------------------------------
// ilrc_release_scan
// parallel owner match over all line entries, with the count of matching
// lines that sit on the second controller
// ----------------------------------------------------------------------------
module ilrc_release_scan #(
    parameter int LINE_COUNT = 16,
    parameter int OWNER_BITS = 8
) (
    input  logic [LINE_COUNT-1:0]                 line_bound,
    input  logic [LINE_COUNT-1:0][OWNER_BITS-1:0] line_owner,
    input  logic [OWNER_BITS-1:0]                 owner,
    output logic [LINE_COUNT-1:0]                 hit_vec,
    output logic [ilrc_pkg::HITS_W-1:0]           slave_hits
);
    import ilrc_pkg::*;

    logic [LINE_COUNT-1:0] slave_vec;

    always_comb begin
        for (int i = 0; i < LINE_COUNT; i++) begin
            hit_vec[i]   = line_bound[i] && (line_owner[i] == owner);
            slave_vec[i] = hit_vec[i] && (i >= SLAVE_BASE);
        end
    end

    assign slave_hits = HITS_W'($countones(slave_vec));

endmodule

FILE: rtl/interrupt_line_router_coalescer.sv
// ----------------------------------------------------------------------------
// interrupt_line_router_coalescer
// binds interrupt lines to owners, keeps the controller mask and cascade
// input in step, and coalesces repeated raises into one pending notification
// ----------------------------------------------------------------------------
// One request is taken every clock cycle unless back pressure holds the flow.
// A request is held in an input register, resolved against the line table by
// one pass of logic and lands in the result register; back pressure on the
// result side stalls the input side directly.
// The line table lives in flip-flops, which lets a release match every line
// at once; the mask and the stray and duplicate totals in a result are the
// values after that request.
`include "interrupt_line_router_coalescer_assert.svh"

module interrupt_line_router_coalescer #(
    parameter int LINE_COUNT = 16,
    parameter int OWNER_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ilrc_pkg::S_TDATA_W-1:0]   s_tdata,   // line, owner
    input  logic [ilrc_pkg::OPCODE_W-1:0]    s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mask_now, notify_owner, miss_count, stray_total, dup_total
    output logic [ilrc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [ilrc_pkg::STATUS_W-1:0]    m_tuser    // status
);
    import ilrc_pkg::*;

    localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

    // input register
    logic                in_valid_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [OWNER_W-1:0]  owner_reg;

    // line table and global state
    logic [LINE_COUNT-1:0]                 line_bound_reg;
    logic [LINE_COUNT-1:0]                 line_pending_reg;
    logic [LINE_COUNT-1:0][OWNER_BITS-1:0] line_owner_reg;
    logic [LINE_COUNT-1:0][MISS_W-1:0]     line_misses_reg;
    logic [MASK_BITS-1:0]                  irq_mask_reg;
    logic [USERS_W-1:0]                    cascade_users_reg;
    logic [TOTAL_W-1:0]                    stray_reg;
    logic [TOTAL_W-1:0]                    dup_reg;

    // result register
    logic                m_valid_reg;
    status_t             status_out_reg;
    logic [OWNER_W-1:0]  notify_out_reg;
    logic [MISS_W-1:0]   miss_out_reg;

    logic                s_acc;
    logic                adv;
    logic [IDX_W-1:0]    idx;
    logic                line_ok;
    logic                cur_bound;
    logic                cur_pending;
    logic [OWNER_BITS-1:0] cur_owner;
    logic [MISS_W-1:0]   cur_misses;
    logic [MISS_W-1:0]   miss_bump;
    logic [WIDE_OWNER_W-1:0] owner_in_wide;
    logic [WIDE_OWNER_W-1:0] owner_out_wide;
    logic [OWNER_BITS-1:0] own;
    logic                is_slave;
    logic [MASK_BITS-1:0] line_bit;
    logic [MASK_BITS-1:0] casc_bit;
    logic [MASK_BITS-1:0] timer_bit;
    logic [LINE_COUNT-1:0] sel;
    logic [LINE_COUNT-1:0] hit_vec;
    logic [HITS_W-1:0]   slave_hits;
    logic [31:0]         hit_wide;
    logic [HITS_W-1:0]   users_wide;
    logic [HITS_W-1:0]   users_left;
    logic                casc_off;

    status_t             status_next;
    logic [MASK_BITS-1:0] mask_next;
    logic [USERS_W-1:0]  users_next;
    logic [TOTAL_W-1:0]  stray_next;
    logic [TOTAL_W-1:0]  dup_next;
    logic [OWNER_W-1:0]  notify_next;
    logic [MISS_W-1:0]   miss_next;
    logic                do_bind;
    logic                do_release;
    logic                do_notify;
    logic                do_coalesce;
    logic                do_ack;

    // handshake
    assign adv      = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_acc) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg    <= s_tuser;
            line_reg  <= s_tdata[LINE_W-1:0];
            owner_reg <= s_tdata[LINE_W+OWNER_W-1:LINE_W];
        end
    end

    // line lookup
    assign idx         = line_reg[IDX_W-1:0];
    assign line_ok     = {1'b0, line_reg} < (LINE_W+1)'(LINE_COUNT);
    assign cur_bound   = line_bound_reg[idx];
    assign cur_pending = line_pending_reg[idx];
    assign cur_owner   = line_owner_reg[idx];
    assign cur_misses  = line_misses_reg[idx];
    assign miss_bump   = (cur_misses == MISS_MAX) ? cur_misses : cur_misses + 1'b1;

    assign owner_in_wide  = WIDE_OWNER_W'(owner_reg);
    assign own            = owner_in_wide[OWNER_BITS-1:0];
    assign owner_out_wide = WIDE_OWNER_W'(cur_owner);

    assign is_slave  = line_reg >= LINE_W'(SLAVE_BASE);
    assign line_bit  = MASK_BITS'(1) << line_reg;
    assign casc_bit  = MASK_BITS'(1) << CASCADE_LINE;
    assign timer_bit = MASK_BITS'(1) << TIMER_LINE;

    always_comb begin
        for (int i = 0; i < LINE_COUNT; i++) begin
            sel[i] = (idx == IDX_W'(i));
        end
    end

    ilrc_release_scan #(
        .LINE_COUNT (LINE_COUNT),
        .OWNER_BITS (OWNER_BITS)
    ) u_release_scan (
        .line_bound (line_bound_reg),
        .line_owner (line_owner_reg),
        .owner      (own),
        .hit_vec    (hit_vec),
        .slave_hits (slave_hits)
    );

    assign hit_wide   = 32'(hit_vec);
    assign users_wide = HITS_W'(cascade_users_reg);
    assign users_left = (users_wide > slave_hits) ? users_wide - slave_hits : '0;
    assign casc_off   = (cascade_users_reg != '0) && (slave_hits >= users_wide);

    // request decode
    always_comb begin
        status_next = ST_OK;
        mask_next   = irq_mask_reg;
        users_next  = cascade_users_reg;
        stray_next  = stray_reg;
        dup_next    = dup_reg;
        notify_next = '0;
        miss_next   = '0;
        do_bind     = 1'b0;
        do_release  = 1'b0;
        do_notify   = 1'b0;
        do_coalesce = 1'b0;
        do_ack      = 1'b0;
        case (opcode_t'(op_reg))
            OP_REGISTER: begin
                if (!line_ok) begin
                    status_next = ST_BAD_LINE;
                end else if (cur_bound) begin
                    status_next = ST_BUSY;
                end else begin
                    do_bind   = 1'b1;
                    mask_next = irq_mask_reg & ~line_bit;
                    if (is_slave) begin
                        if (cascade_users_reg != CASCADE_MAX) begin
                            users_next = cascade_users_reg + 1'b1;
                        end
                        mask_next = mask_next & ~casc_bit;
                    end
                end
            end
            OP_RELEASE: begin
                do_release = 1'b1;
                mask_next  = irq_mask_reg | hit_wide[MASK_BITS-1:0]
                             | (casc_off ? casc_bit : '0);
                users_next = users_left[USERS_W-1:0];
            end
            OP_RAISE: begin
                if (!line_ok) begin
                    status_next = ST_BAD_LINE;
                end else if (!cur_bound) begin
                    status_next = ST_STRAY;
                    if (stray_reg != TOTAL_MAX) begin
                        stray_next = stray_reg + 1'b1;
                    end
                end else if (!cur_pending) begin
                    status_next = ST_NOTIFY;
                    do_notify   = 1'b1;
                    notify_next = owner_out_wide[OWNER_W-1:0];
                    miss_next   = MISS_W'(1);
                end else begin
                    status_next = ST_COALESCED;
                    do_coalesce = 1'b1;
                    miss_next   = miss_bump;
                    if (dup_reg != TOTAL_MAX) begin
                        dup_next = dup_reg + 1'b1;
                    end
                end
            end
            OP_ACK: begin
                if (!line_ok) begin
                    status_next = ST_BAD_LINE;
                end else begin
                    do_ack = 1'b1;
                end
            end
            OP_START_TIMER: begin
                mask_next = irq_mask_reg & ~timer_bit;
            end
            default: begin
            end
        endcase
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_bound_reg    <= '0;
            line_pending_reg  <= '0;
            line_owner_reg    <= '0;
            line_misses_reg   <= '0;
            irq_mask_reg      <= MASK_ALL;
            cascade_users_reg <= '0;
            stray_reg         <= '0;
            dup_reg           <= '0;
        end else if (adv) begin
            irq_mask_reg      <= mask_next;
            cascade_users_reg <= users_next;
            stray_reg         <= stray_next;
            dup_reg           <= dup_next;
            for (int i = 0; i < LINE_COUNT; i++) begin
                if (do_bind && sel[i]) begin
                    line_bound_reg[i]   <= 1'b1;
                    line_owner_reg[i]   <= own;
                    line_pending_reg[i] <= 1'b0;
                    line_misses_reg[i]  <= '0;
                end
                if (do_release && hit_vec[i]) begin
                    line_bound_reg[i]   <= 1'b0;
                    line_owner_reg[i]   <= '0;
                    line_pending_reg[i] <= 1'b0;
                    line_misses_reg[i]  <= '0;
                end
                if (do_notify && sel[i]) begin
                    line_pending_reg[i] <= 1'b1;
                    line_misses_reg[i]  <= MISS_W'(1);
                end
                if (do_coalesce && sel[i]) begin
                    line_misses_reg[i] <= miss_bump;
                end
                if (do_ack && sel[i]) begin
                    line_pending_reg[i] <= 1'b0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            status_out_reg <= status_next;
            notify_out_reg <= notify_next;
            miss_out_reg   <= miss_next;
        end
    end

    // mask and totals only move when a new result is loaded
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_out_reg;
    assign m_tdata  = {dup_reg, stray_reg, miss_out_reg, notify_out_reg, irq_mask_reg};

    `ILRC_ASSERT_NEXT(a_take_fills_input, aclk, aresetn, s_acc, in_valid_reg, "request lost")
    `ILRC_ASSERT_NOW(a_pending_bound, aclk, aresetn, 1'b1, (line_pending_reg & ~line_bound_reg) == '0, "pending on unbound line")
    `ILRC_ASSERT_NOW(a_stray_monotone, aclk, aresetn, $past(aresetn), stray_reg >= $past(stray_reg), "stray total fell")
    `ILRC_ASSERT_NOW(a_dup_monotone, aclk, aresetn, $past(aresetn), dup_reg >= $past(dup_reg), "dup total fell")

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// interrupt line router and coalescer testbench
// drives register, release, raise, acknowledge and timer requests into the
// router, predicts every result from its own copy of the line table, mask and
// totals, and compares each result field by field. random idles on both
// sides, one long result-side hold-off and a back to back raise burst
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ilrc_pkg::*;

    localparam int LINES           = 16;
    localparam int OWNER_BITS_CFG  = 8;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_PRINTED     = 40;
    localparam int BURST_RAISES    = 16;
    localparam int BURST_LINE      = 5;

    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [OWNER_W-1:0]  OWNER_KEEP     = OWNER_W'((1 << OWNER_BITS_CFG) - 1);

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [MASK_BITS-1:0] mask;
        logic [OWNER_W-1:0]   notify;
        logic [MISS_W-1:0]    misses;
        logic [TOTAL_W-1:0]   strays;
        logic [TOTAL_W-1:0]   dups;
    } route_outcome_t;

    class irq_route_scoreboard;
        bit                   bound [LINES];
        logic [OWNER_W-1:0]   owner_of [LINES];
        bit                   pending [LINES];
        logic [MISS_W-1:0]    misses [LINES];
        logic [MASK_BITS-1:0] mask;
        logic [USERS_W-1:0]   cascade_users;
        logic [TOTAL_W-1:0]   strays;
        logic [TOTAL_W-1:0]   dups;
        route_outcome_t       routing_replies [$];
        int                   mismatches;

        function new();
            for (int i = 0; i < LINES; i++) begin
                bound[i]    = 1'b0;
                owner_of[i] = '0;
                pending[i]  = 1'b0;
                misses[i]   = '0;
            end
            mask          = MASK_ALL;
            cascade_users = '0;
            strays        = '0;
            dups          = '0;
            mismatches    = 0;
        endfunction

        function void set_mask_bit(int unsigned idx, bit off);
            if (idx < MASK_BITS) begin
                mask[idx] = off;
            end
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [LINE_W-1:0] line,
                                   logic [OWNER_W-1:0] owner_in);
            route_outcome_t     r;
            logic [OWNER_W-1:0] own;
            bit                 ok;
            own      = owner_in & OWNER_KEEP;
            ok       = line < LINES;
            r.status = ST_OK;
            r.notify = '0;
            r.misses = '0;
            case (op)
                OP_REGISTER: begin
                    if (!ok) begin
                        r.status = ST_BAD_LINE;
                    end else if (bound[line]) begin
                        r.status = ST_BUSY;
                    end else begin
                        bound[line]    = 1'b1;
                        owner_of[line] = own;
                        pending[line]  = 1'b0;
                        misses[line]   = '0;
                        set_mask_bit(line, 1'b0);
                        if (line >= SLAVE_BASE) begin
                            if (cascade_users != CASCADE_MAX) cascade_users++;
                            set_mask_bit(CASCADE_LINE, 1'b0);
                        end
                    end
                end
                OP_RELEASE: begin
                    for (int i = 0; i < LINES; i++) begin
                        if (bound[i] && owner_of[i] == own) begin
                            set_mask_bit(i, 1'b1);
                            if (i >= SLAVE_BASE && cascade_users != 0) begin
                                cascade_users--;
                                if (cascade_users == 0) set_mask_bit(CASCADE_LINE, 1'b1);
                            end
                            bound[i]    = 1'b0;
                            owner_of[i] = '0;
                            pending[i]  = 1'b0;
                            misses[i]   = '0;
                        end
                    end
                end
                OP_RAISE: begin
                    if (!ok) begin
                        r.status = ST_BAD_LINE;
                    end else if (!bound[line]) begin
                        r.status = ST_STRAY;
                        if (strays != TOTAL_MAX) strays++;
                    end else if (!pending[line]) begin
                        r.status      = ST_NOTIFY;
                        pending[line] = 1'b1;
                        misses[line]  = 1;
                        r.notify      = owner_of[line];
                        r.misses      = 1;
                    end else begin
                        r.status = ST_COALESCED;
                        if (misses[line] != MISS_MAX) misses[line]++;
                        if (dups != TOTAL_MAX) dups++;
                        r.misses = misses[line];
                    end
                end
                OP_ACK: begin
                    if (!ok) r.status = ST_BAD_LINE;
                    else pending[line] = 1'b0;
                end
                OP_START_TIMER: begin
                    set_mask_bit(TIMER_LINE, 1'b0);
                end
                default: begin
                end
            endcase
            r.mask   = mask;
            r.strays = strays;
            r.dups   = dups;
            routing_replies.push_back(r);
        endfunction

        task report_mismatch(string field, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
            if (mismatches < MAX_PRINTED) begin
                $display("mismatch %s: got %h expected %h", field, got, want);
            end
            mismatches++;
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [M_TDATA_W-1:0] data);
            route_outcome_t want;
            if (routing_replies.size() == 0) begin
                report_mismatch("result with no request waiting, status", status, '0);
                return;
            end
            want = routing_replies.pop_front();
            if (status !== want.status)       report_mismatch("status", status, want.status);
            if (data[15:0] !== want.mask)     report_mismatch("mask_now", data[15:0], want.mask);
            if (data[23:16] !== want.notify)  report_mismatch("notify_owner", data[23:16], want.notify);
            if (data[39:24] !== want.misses)  report_mismatch("miss_count", data[39:24], want.misses);
            if (data[71:40] !== want.strays)  report_mismatch("stray_total", data[71:40], want.strays);
            if (data[103:72] !== want.dups)   report_mismatch("dup_total", data[103:72], want.dups);
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // line, owner
    logic [OPCODE_W-1:0]   s_tuser  = '0;   // opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // mask_now, notify_owner, miss_count, stray_total, dup_total
    logic [STATUS_W-1:0]   m_tuser;         // status

    bit                    idle_on     = 1'b1;
    bit                    hold_toggle = 1'b0;
    int                    quiet_cycles = 0;
    irq_route_scoreboard   sb = new();

    logic [OWNER_W-1:0] owner_pool [6] = '{8'h00, 8'h01, 8'h5A, 8'h80, 8'hA5, 8'hFF};

    interrupt_line_router_coalescer #(
        .LINE_COUNT (LINES),
        .OWNER_BITS (OWNER_BITS_CFG)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    task send_request(logic [OPCODE_W-1:0] op, logic [LINE_W-1:0] line, logic [OWNER_W-1:0] owner);
        while (idle_on && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, owner, line};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, line, owner);
    endtask

    task send_random_request();
        int unsigned          pick;
        logic [OPCODE_W-1:0]  op;
        logic [LINE_W-1:0]    line;
        logic [OWNER_W-1:0]   owner;
        pick = $urandom_range(0, 99);
        if (pick < 25)      op = OP_REGISTER;
        else if (pick < 65) op = OP_RAISE;
        else if (pick < 80) op = OP_ACK;
        else if (pick < 89) op = OP_RELEASE;
        else if (pick < 95) op = OP_START_TIMER;
        else                op = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if ($urandom_range(0, 99) < 9) line = LINE_W'($urandom_range(LINES, 31));
        else                           line = LINE_W'($urandom_range(0, LINES - 1));
        if ($urandom_range(0, 99) < 15) owner = OWNER_W'($urandom_range(0, 255));
        else                            owner = owner_pool[$urandom_range(0, 5)];
        send_request(op, line, owner);
    endtask

    // result side: checks, random idles and the long hold-off
    initial begin
        bit seen_toggle = 1'b0;
        int hold_left   = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= !(idle_on && $urandom_range(0, 99) < 9);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests
        send_request(OP_START_TIMER, 5'd0, 8'h00);
        send_request(OP_RAISE, 5'd0, 8'h00);
        send_request(OP_REGISTER, 5'd0, 8'h00);
        send_request(OP_REGISTER, 5'd15, 8'hFF);
        send_request(OP_REGISTER, 5'd8, 8'hFF);
        send_request(OP_REGISTER, 5'd15, 8'h01);
        send_request(OP_REGISTER, 5'd16, 8'h01);
        send_request(OP_REGISTER, 5'd31, 8'hFF);
        send_request(OP_RAISE, 5'd31, 8'h00);
        send_request(OP_RAISE, 5'd15, 8'h00);
        send_request(OP_RAISE, 5'd15, 8'h00);
        send_request(OP_RAISE, 5'd15, 8'h00);
        send_request(OP_ACK, 5'd15, 8'h00);
        send_request(OP_ACK, 5'd31, 8'h00);
        send_request(OP_ACK, 5'd4, 8'h00);
        send_request(OP_RAISE, 5'd15, 8'h00);
        send_request(OP_REGISTER, 5'd2, 8'h80);
        send_request(OP_RELEASE, 5'd31, 8'hFF);
        send_request(OP_RAISE, 5'd2, 8'h00);
        send_request(OP_RELEASE, 5'd0, 8'h07);
        send_request(OP_SPARE_FIRST, 5'd1, 8'h01);
        send_request(OP_SPARE_LAST, 5'd30, 8'hFE);
        send_request(OP_RAISE, 5'd15, 8'h00);
        send_request(OP_RELEASE, 5'd0, 8'h00);
        send_request(OP_START_TIMER, 5'd31, 8'hFF);

        repeat (580) send_random_request();

        // result side stalls while requests keep coming
        hold_toggle <= ~hold_toggle;
        repeat (420) send_random_request();

        idle_on <= 1'b0;
        repeat (600) send_random_request();

        // back to back raises on one line
        if (sb.bound[BURST_LINE]) send_request(OP_RELEASE, 5'd0, sb.owner_of[BURST_LINE]);
        send_request(OP_REGISTER, LINE_W'(BURST_LINE), 8'h42);
        repeat (BURST_RAISES) send_request(OP_RAISE, LINE_W'(BURST_LINE), 8'h00);
        idle_on <= 1'b1;
        send_request(OP_ACK, LINE_W'(BURST_LINE), 8'h00);
        send_request(OP_RAISE, LINE_W'(BURST_LINE), 8'h00);
        repeat (30) send_random_request();

        s_tvalid <= 1'b0;
        while (sb.routing_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ilrc_pkg.sv
rtl/ilrc_release_scan.sv
rtl/interrupt_line_router_coalescer.sv
dv/testbench.sv
